/* design/smam_pkg.sv */
// shared types and constants for the sparse matrix add merge core
// no dependencies; imported by the core top level, smam_pick and the testbench
`timescale 1ns / 1ps

package smam_pkg;

   // default list capacity and the cap on results per merge
   localparam int LIST_DEPTH_DEF = 16;
   localparam int RESULT_CAP     = 32;
   localparam int COUNT_W        = 6;

   // row * num_cols + col fits in 8 + 9 + 1 bits
   localparam int LIN_W = 18;

   // request codes
   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_START  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         term_row;
      logic [7:0]         term_col;
      logic signed [31:0] term_value;
   } req_word_type;

   typedef struct packed {
      logic [7:0]           out_row;
      logic [7:0]           out_col;
      logic signed [31:0]   out_value;
      logic                 has_term;
      logic                 last;
      logic [COUNT_W-1:0]   term_count;
   } rsp_word_type;

   // one stored list entry
   typedef struct packed {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] value;
   } entry_type;

   // decision of one merge step
   typedef struct packed {
      logic      emit;
      logic      adv_a;
      logic      adv_b;
      logic      done;
      entry_type term;
   } pick_type;

endpackage

/* design/sparse_matrix_add_merge_core.sv */
// top level of the sparse matrix add merge core: list memories, merge sequencer, result register
// depends on smam_pkg, smam_ram, smam_pick
`timescale 1ns / 1ps

// Adds two sparse matrices held as coordinate lists A and B. A load word (req_type 0 or 1)
// appends one term to a list; a term for a full list is dropped. A start word (req_type 2)
// walks both list memories, one merge step per cycle, and returns every surviving term on
// rsp_word with rsp_strobe high for exactly one cycle; the receiver cannot stall, so each
// word must be taken when shown. Terms are ordered by row * num_cols + col, equal positions
// are summed (32-bit wrap) and dropped on zero. The final word carries last and the term
// count; an empty merge gives one marker word with has_term low. busy stays high from the
// start word through the merge steps (one per entry of A plus one per entry of B, minus one
// per matched pair) and the closing step. Each result word appears in the cycle after the
// step that found the following term, since a term is held back until it is known whether
// it is the last. At most 32 terms are returned.
// num_cols is written through the csr port while the core is idle.
module sparse_matrix_add_merge_core
   import smam_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   // result channel
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   // num_cols register
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [8:0]   csr_wdata
);

   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type    state_ff,      state_in;
   logic [CW-1:0] ia_ff,        ia_in;
   logic [CW-1:0] ib_ff,        ib_in;
   logic [CW-1:0] a_cnt_ff,     a_cnt_in;
   logic [CW-1:0] b_cnt_ff,     b_cnt_in;
   logic [8:0]   num_cols_ff,   num_cols_in;
   entry_type    held_ff,       held_in;
   logic         held_valid_ff, held_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type rsp_word_ff,   rsp_word_in;

   logic         accept;
   entry_type    load_entry;
   logic         wr_a, wr_b;
   logic [$bits(entry_type)-1:0] rd_a, rd_b;
   pick_type     pick;
   logic         emit_ok;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   assign load_entry.row   = req_word.term_row;
   assign load_entry.col   = req_word.term_col;
   assign load_entry.value = req_word.term_value;

   // appends go to the current fill position of the list
   assign wr_a = accept && (req_word.req_type == REQ_LOAD_A) && (a_cnt_ff < CW'(LIST_DEPTH));
   assign wr_b = accept && (req_word.req_type == REQ_LOAD_B) && (b_cnt_ff < CW'(LIST_DEPTH));

   // read address follows the next head index, so while merging the ram output is mem[ia_ff]
   smam_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (LIST_DEPTH)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (a_cnt_ff[AW-1:0]),
      .wr_data (load_entry),
      .rd_addr (ia_in[AW-1:0]),
      .rd_data (rd_a)
   );

   smam_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (LIST_DEPTH)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (b_cnt_ff[AW-1:0]),
      .wr_data (load_entry),
      .rd_addr (ib_in[AW-1:0]),
      .rd_data (rd_b)
   );

   smam_pick u_pick (
      .num_cols (num_cols_ff),
      .a_entry  (entry_type'(rd_a)),
      .b_entry  (entry_type'(rd_b)),
      .a_ok     (ia_ff < a_cnt_ff),
      .b_ok     (ib_ff < b_cnt_ff),
      .pick     (pick)
   );

   // terms past the result cap are consumed but not kept
   assign emit_ok = pick.emit && (count_ff < COUNT_W'(RESULT_CAP));

   always_comb begin
      state_in      = state_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      a_cnt_in      = a_cnt_ff;
      b_cnt_in      = b_cnt_ff;
      num_cols_in   = num_cols_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      if (csr_valid && csr_ready) begin
         num_cols_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            ia_in = '0;
            ib_in = '0;
            if (wr_a) begin
               a_cnt_in = a_cnt_ff + CW'(1);
            end
            if (wr_b) begin
               b_cnt_in = b_cnt_ff + CW'(1);
            end
            if (accept && (req_word.req_type == REQ_START)) begin
               state_in      = ST_MERGE;
               held_valid_in = 1'b0;
               count_in      = '0;
            end
         end
         ST_MERGE: begin
            ia_in = ia_ff + CW'(pick.adv_a);
            ib_in = ib_ff + CW'(pick.adv_b);
            if (pick.done) begin
               // close out: last held term, or the empty marker
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '0;
               rsp_word_in.last = 1'b1;
               if (held_valid_ff) begin
                  rsp_word_in.out_row    = held_ff.row;
                  rsp_word_in.out_col    = held_ff.col;
                  rsp_word_in.out_value  = held_ff.value;
                  rsp_word_in.has_term   = 1'b1;
                  rsp_word_in.term_count = count_ff;
               end
               a_cnt_in = '0;
               b_cnt_in = '0;
               ia_in    = '0;
               ib_in    = '0;
               state_in = ST_IDLE;
            end else if (emit_ok) begin
               // a newer term exists, so the held one is not the last
               if (held_valid_ff) begin
                  rsp_strobe_in        = 1'b1;
                  rsp_word_in          = '0;
                  rsp_word_in.out_row  = held_ff.row;
                  rsp_word_in.out_col  = held_ff.col;
                  rsp_word_in.out_value = held_ff.value;
                  rsp_word_in.has_term = 1'b1;
               end
               held_in       = pick.term;
               held_valid_in = 1'b1;
               count_in      = count_ff + COUNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ia_ff         <= '0;
         ib_ff         <= '0;
         a_cnt_ff      <= '0;
         b_cnt_ff      <= '0;
         num_cols_ff   <= 9'd256;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         a_cnt_ff      <= a_cnt_in;
         b_cnt_ff      <= b_cnt_in;
         num_cols_ff   <= num_cols_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      held_ff     <= held_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // list fill never passes capacity
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (a_cnt_ff <= CW'(LIST_DEPTH)) && (b_cnt_ff <= CW'(LIST_DEPTH)))
      else $error("list count beyond capacity");

   // head indices stay within the filled part while merging
   head_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (ia_ff <= a_cnt_ff) && (ib_ff <= b_cnt_ff))
      else $error("merge head past list fill");

   // results only come out of a merge
   rsp_after_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a merge");

   // the empty marker is always the closing word with zero count
   empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.has_term) |-> (rsp_word.last && rsp_word.term_count == '0))
      else $error("malformed empty marker");

   // the closing word leaves both lists empty
   lists_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.last) |-> (a_cnt_ff == '0) && (b_cnt_ff == '0) && !busy)
      else $error("lists not cleared after merge");

endmodule

/* design/smam_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module smam_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* design/smam_pick.sv */
// one merge step: linear index compare of the two head entries and term select
// depends on smam_pkg
`timescale 1ns / 1ps

module smam_pick
   import smam_pkg::*;
(
   input  logic [8:0] num_cols,
   input  entry_type  a_entry,
   input  entry_type  b_entry,
   input  logic       a_ok,
   input  logic       b_ok,
   output pick_type   pick
);

   logic [LIN_W-1:0] lin_a;
   logic [LIN_W-1:0] lin_b;
   logic [31:0]      sum;

   assign lin_a = LIN_W'(a_entry.row) * LIN_W'(num_cols) + LIN_W'(a_entry.col);
   assign lin_b = LIN_W'(b_entry.row) * LIN_W'(num_cols) + LIN_W'(b_entry.col);
   assign sum   = a_entry.value + b_entry.value;

   always_comb begin
      pick      = '0;
      pick.term = a_entry;
      pick.done = !a_ok && !b_ok;
      if (a_ok && b_ok) begin
         if (lin_a < lin_b) begin
            pick.emit  = 1'b1;
            pick.adv_a = 1'b1;
         end else if (lin_a > lin_b) begin
            pick.emit  = 1'b1;
            pick.adv_b = 1'b1;
            pick.term  = b_entry;
         end else begin
            // matching position: summed term vanishes when it cancels
            pick.emit       = (sum != 32'd0);
            pick.adv_a      = 1'b1;
            pick.adv_b      = 1'b1;
            pick.term.value = sum;
         end
      end else if (a_ok) begin
         pick.emit  = 1'b1;
         pick.adv_a = 1'b1;
      end else if (b_ok) begin
         pick.emit  = 1'b1;
         pick.adv_b = 1'b1;
         pick.term  = b_entry;
      end
   end

endmodule

/* tb/smam_merge_checker.sv */
`timescale 1ns / 1ps
// checker for the sparse matrix add merge core: mirrors both term lists and num_cols,
// predicts the result words of every start word and compares them as they are shown
// depends on smam_pkg
module smam_merge_checker
   import smam_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_strobe,
   input  rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [8:0]   csr_wdata,
   output int           mismatches,
   output int           pending
);

   entry_type    list_a[$];
   entry_type    list_b[$];
   rsp_word_type merged_words[$];
   logic [8:0]   num_cols;
   int           miss_count;
   entry_type    loaded;
   rsp_word_type want;

   // row-major position, unsigned and unchecked
   function automatic logic [31:0] position(entry_type e);
      return {24'd0, e.row} * {23'd0, num_cols} + {24'd0, e.col};
   endfunction

   function automatic rsp_word_type term_word(entry_type e);
      rsp_word_type w;
      w = '0;
      w.out_row   = e.row;
      w.out_col   = e.col;
      w.out_value = e.value;
      w.has_term  = 1'b1;
      return w;
   endfunction

   function automatic string describe(rsp_word_type w);
      return $sformatf("row %0d col %0d value %0d has_term %0b last %0b count %0d",
                       w.out_row, w.out_col, w.out_value, w.has_term, w.last,
                       w.term_count);
   endfunction

   task automatic predict_merge();
      rsp_word_type terms[$];
      rsp_word_type w;
      entry_type    ea;
      entry_type    eb;
      logic [31:0]  xa;
      logic [31:0]  xb;
      int           ia;
      int           ib;
      int           i;
      ia = 0;
      ib = 0;
      while (ia < list_a.size() && ib < list_b.size()) begin
         ea = list_a[ia];
         eb = list_b[ib];
         xa = position(ea);
         xb = position(eb);
         if (xa < xb) begin
            terms.push_back(term_word(ea));
            ia++;
         end else if (xa > xb) begin
            terms.push_back(term_word(eb));
            ib++;
         end else begin
            // same position: wrapped sum, nothing left when it cancels
            ea.value = ea.value + eb.value;
            if (ea.value != 32'd0) terms.push_back(term_word(ea));
            ia++;
            ib++;
         end
      end
      while (ia < list_a.size()) begin
         terms.push_back(term_word(list_a[ia]));
         ia++;
      end
      while (ib < list_b.size()) begin
         terms.push_back(term_word(list_b[ib]));
         ib++;
      end
      while (terms.size() > RESULT_CAP) w = terms.pop_back();
      if (terms.size() == 0) begin
         // empty merge marker
         w = '0;
         w.last = 1'b1;
         merged_words.push_back(w);
      end
      for (i = 0; i < terms.size(); i++) begin
         w = terms[i];
         if (i == terms.size() - 1) begin
            w.last       = 1'b1;
            w.term_count = COUNT_W'(terms.size());
         end
         merged_words.push_back(w);
      end
      list_a.delete();
      list_b.delete();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_a.delete();
         list_b.delete();
         merged_words.delete();
         num_cols   = 9'd256;
         miss_count = 0;
      end else begin
         if (csr_valid && csr_ready) num_cols = csr_wdata;
         if (start && !busy) begin
            loaded = {req_word.term_row, req_word.term_col, req_word.term_value};
            case (req_word.req_type)
               REQ_LOAD_A: begin
                  if (list_a.size() < LIST_DEPTH) list_a.push_back(loaded);
               end
               REQ_LOAD_B: begin
                  if (list_b.size() < LIST_DEPTH) list_b.push_back(loaded);
               end
               REQ_START: begin
                  predict_merge();
               end
               default: begin
                  // unknown code, no effect
               end
            endcase
         end
         if (rsp_strobe) begin
            if (merged_words.size() == 0) begin
               if (miss_count < 10)
                  $display("unexpected result word at %0t: %s", $time, describe(rsp_word));
               miss_count++;
            end else begin
               want = merged_words.pop_front();
               if (rsp_word.out_row    !== want.out_row    ||
                   rsp_word.out_col    !== want.out_col    ||
                   rsp_word.out_value  !== want.out_value  ||
                   rsp_word.has_term   !== want.has_term   ||
                   rsp_word.last       !== want.last       ||
                   rsp_word.term_count !== want.term_count) begin
                  if (miss_count < 10)
                     $display("result mismatch at %0t: expected %s, got %s",
                              $time, describe(want), describe(rsp_word));
                  miss_count++;
               end
            end
         end
      end
      mismatches <= miss_count;
      pending    <= merged_words.size();
   end

endmodule

/* tb/tb_sparse_matrix_add_merge_core.sv */
`timescale 1ns / 1ps
// testbench top for the sparse matrix add merge core: clock, reset, load and start words,
// num_cols writes and the verdict; depends on smam_pkg, smam_merge_checker and the core
module tb_sparse_matrix_add_merge_core;
   import smam_pkg::*;

   // code that the core ignores
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [8:0]   csr_wdata = '0;
   int           mismatches;
   int           pending;

   // stimulus side copy of num_cols, used to sort the generated lists and pick their columns
   logic [8:0]   cols = 9'd256;
   int           items = 0;
   // no idle gaps while set
   bit           calm = 1'b1;
   int           phase;
   // lists of one phase, built before they are sent
   req_word_type list_buf[2][20];
   int           list_len[2];

   always #2 clock = ~clock;

   sparse_matrix_add_merge_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   smam_merge_checker merge_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   function automatic req_word_type make_word(logic [1:0] kind, logic [7:0] row,
                                              logic [7:0] col, logic [31:0] value);
      req_word_type w;
      w.req_type   = kind;
      w.term_row   = row;
      w.term_col   = col;
      w.term_value = value;
      return w;
   endfunction

   function automatic logic [31:0] key_of(req_word_type w);
      return {24'd0, w.term_row} * {23'd0, cols} + {24'd0, w.term_col};
   endfunction

   // mostly random values, with the 32-bit extremes and zero mixed in
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'd1;
         4: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type random_term(logic [1:0] kind);
      logic [7:0] col;
      // columns mostly inside the matrix, now and then beyond num_cols
      if (cols != 9'd0 && cols <= 9'd256 && $urandom_range(0, 7) != 0)
         col = 8'($urandom_range(0, cols - 1));
      else
         col = 8'($urandom_range(0, 255));
      return make_word(kind, 8'($urandom_range(0, 255)), col, pick_value());
   endfunction

   // one word on the request channel; start is left high so back to back words
   // need no low cycle, every other path lowers it
   task automatic send_word(req_word_type w);
      if (!calm && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (w.req_type != REQ_UNUSED) items++;
   endtask

   // wait until every predicted result word has been seen and the core is idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_num_cols(logic [8:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cols = value;
   endtask

   // insertion into one list, kept in position order when ordered is set
   task automatic place(int side, req_word_type w, bit ordered);
      int i;
      i = list_len[side];
      while (ordered && i > 0 && key_of(list_buf[side][i-1]) > key_of(w)) begin
         list_buf[side][i] = list_buf[side][i-1];
         i--;
      end
      list_buf[side][i] = w;
      list_len[side]++;
   endtask

   // one matrix pair: build both lists, send their words interleaved, then start
   task automatic run_phase(bit ordered);
      req_word_type w;
      req_word_type a;
      int           na;
      int           nb;
      int           ia;
      int           ib;
      int           k;
      list_len[0] = 0;
      list_len[1] = 0;
      // mostly short lists, sometimes past capacity so terms get dropped
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
      for (k = 0; k < na; k++) place(0, random_term(REQ_LOAD_A), ordered);
      for (k = 0; k < nb; k++) begin
         w = random_term(REQ_LOAD_B);
         if (list_len[0] > 0 && $urandom_range(0, 1) == 1) begin
            // reuse a position of list A so the two terms meet in the merge
            a = list_buf[0][$urandom_range(0, list_len[0] - 1)];
            w.term_row = a.term_row;
            w.term_col = a.term_col;
            case ($urandom_range(0, 2))
               0: w.term_value = -a.term_value;
               1: w.term_value = a.term_value;
               default: begin
                  // keep the random value
               end
            endcase
         end
         place(1, w, ordered);
      end
      ia = 0;
      ib = 0;
      while (ia < list_len[0] || ib < list_len[1]) begin
         if ($urandom_range(0, 15) == 0)
            send_word(make_word(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom));
         if (ib >= list_len[1] || (ia < list_len[0] && $urandom_range(0, 1) == 0)) begin
            send_word(list_buf[0][ia]);
            ia++;
         end else begin
            send_word(list_buf[1][ib]);
            ib++;
         end
      end
      // position and value fields of a start word are don't care
      send_word(make_word(REQ_START, 8'($urandom), 8'($urandom), $urandom));
   endtask

   // num_cols settings in turn: the extremes first, then odd ones, then random
   function automatic logic [8:0] cols_choice(int n);
      case (n)
         0: return 9'd1;
         1: return 9'd511;
         2: return 9'd0;
         3: return 9'd256;
         4: return 9'd255;
         5: return 9'd257;
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty merge right after reset gives the marker word
      send_word(make_word(REQ_START, 8'd0, 8'd0, 32'd0));
      // extremes of position and value: wrapped sum at the origin, a stored zero,
      // and a pair at the far corner that cancels through the wrap
      send_word(make_word(REQ_LOAD_A, 8'd0, 8'd0, 32'h7FFF_FFFF));
      send_word(make_word(REQ_LOAD_A, 8'd255, 8'd255, 32'h8000_0000));
      send_word(make_word(REQ_LOAD_B, 8'd0, 8'd0, 32'd1));
      send_word(make_word(REQ_LOAD_B, 8'd10, 8'd20, 32'd0));
      send_word(make_word(REQ_LOAD_B, 8'd255, 8'd255, 32'h8000_0000));
      send_word(make_word(REQ_UNUSED, 8'd255, 8'd255, 32'hFFFF_FFFF));
      send_word(make_word(REQ_START, 8'd255, 8'd255, 32'hFFFF_FFFF));
      // single pair that cancels, so the merge is empty
      send_word(make_word(REQ_LOAD_A, 8'd5, 8'd5, 32'd100));
      send_word(make_word(REQ_LOAD_B, 8'd5, 8'd5, -32'sd100));
      send_word(make_word(REQ_START, 8'd0, 8'd0, 32'd0));
      // list A out of order is merged as loaded
      send_word(make_word(REQ_LOAD_A, 8'd9, 8'd9, 32'd1));
      send_word(make_word(REQ_LOAD_A, 8'd1, 8'd1, 32'd2));
      send_word(make_word(REQ_LOAD_B, 8'd3, 8'd3, 32'd3));
      send_word(make_word(REQ_START, 8'd0, 8'd0, 32'd0));
      // one list empty, the other drains as remainder
      send_word(make_word(REQ_LOAD_A, 8'd0, 8'd1, 32'd5));
      send_word(make_word(REQ_START, 8'd0, 8'd0, 32'd0));
      send_word(make_word(REQ_LOAD_B, 8'd2, 8'd2, -32'sd7));
      send_word(make_word(REQ_START, 8'd0, 8'd0, 32'd0));

      // random phases; num_cols changes every fifth phase, the other writes
      // only happen once the core has gone quiet
      phase = 0;
      while (items < 430) begin
         calm = (items > 380) || ($urandom_range(0, 3) == 0);
         if (phase % 5 == 4)
            write_num_cols(cols_choice(phase / 5));
         else if ($urandom_range(0, 7) == 0)
            drain();
         run_phase($urandom_range(0, 5) != 0);
         phase++;
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
